// ----- hw/rtl/mpa_pkg.sv -----
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the streaming 2-d max pooling block with argmax.
// ----------------------------------------------------------------------------
package mpa_pkg;

	// parameter defaults
	localparam int DEF_MAX_HEIGHT  = 256;
	localparam int DEF_MAX_WIDTH   = 256;
	localparam int DEF_MAX_KERNEL  = 8;
	localparam int DEF_SAMPLE_BITS = 16;

	// fixed field widths
	localparam int DIM_W      = 9;   // plane size and position
	localparam int KERN_W     = 4;   // kernel and stride
	localparam int PAD_W      = 3;   // padding
	localparam int CNT_W      = 10;  // window counts, quotients, limits
	localparam int IDX_W      = 16;  // raster index of argmax
	localparam int COORD_W    = 8;   // output row and column
	localparam int ARITH_W    = 16;  // signed window bound arithmetic
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// register reset values
	localparam logic [DIM_W-1:0]  RST_DIM    = DIM_W'(2);
	localparam logic [KERN_W-1:0] RST_KERN   = KERN_W'(2);
	localparam logic [PAD_W-1:0]  RST_PAD    = PAD_W'(0);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_HEIGHT   = 3'd0,
		REG_IN_WIDTH    = 3'd1,
		REG_KERNEL_ROWS = 3'd2,
		REG_KERNEL_COLS = 3'd3,
		REG_STRIDE_ROWS = 3'd4,
		REG_STRIDE_COLS = 3'd5,
		REG_PAD_ROWS    = 3'd6,
		REG_PAD_COLS    = 3'd7
	} reg_idx_t;

	// divisions run at plane start
	typedef enum logic [1:0] {
		DIV_OUT_H  = 2'd0,
		DIV_OUT_W  = 2'd1,
		DIV_SEED_R = 2'd2,
		DIV_SEED_C = 2'd3
	} div_sel_t;

	typedef struct packed {
		logic     accept;
		logic     div_start;
		logic     div_store;
		div_sel_t div_sel;
		logic     range;
		logic     rd;
		logic     wr;
		logic     step_pw;
		logic     step_ph;
		logic     adv;
	} dp_cmd_t;

	typedef struct packed {
		logic plane_start;
		logic div_done;
		logic any;
		logic emit;
		logic out_free;
		logic pw_end;
		logic ph_end;
	} dp_stat_t;

endpackage

// ----- hw/rtl/mpa_ram.sv -----
// ----------------------------------------------------------------------------
// mpa_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module mpa_ram
	import mpa_pkg::*;
#(
	parameter int WIDTH = DEF_SAMPLE_BITS,
	parameter int DEPTH = DEF_MAX_KERNEL * DEF_MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/mpa_div.sv -----
// ----------------------------------------------------------------------------
// mpa_div
// Restoring divider, one quotient bit per cycle, for the plane setup.
// ----------------------------------------------------------------------------
module mpa_div
	import mpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CNT_W-1:0]  dividend,
	input  logic [KERN_W-1:0] divisor,
	output logic              done,
	output logic [CNT_W-1:0]  quotient,
	output logic [KERN_W-1:0] remainder
);

	localparam int CW = $clog2(CNT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [CNT_W-1:0]  quo_q;
	logic [KERN_W-1:0] rem_q;
	logic [KERN_W:0]   shifted;
	logic [KERN_W+1:0] trial;
	logic              neg;

	assign shifted = {rem_q, quo_q[CNT_W-1]};
	assign trial   = {1'b0, shifted} - {2'b0, divisor};
	assign neg     = trial[KERN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(CNT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[CNT_W-2:0], ~neg};
			rem_q <= neg ? shifted[KERN_W-1:0] : trial[KERN_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- hw/rtl/mpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// mpa_ctrl
// Sequencer: plane setup divisions, then one read/update pass per window
// that covers the current sample.
// ----------------------------------------------------------------------------
module mpa_ctrl
	import mpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DIV_GO   = 7'b0000010,
		S_DIV_WAIT = 7'b0000100,
		S_RANGE    = 7'b0001000,
		S_RD       = 7'b0010000,
		S_WR       = 7'b0100000,
		S_ADV      = 7'b1000000
	} state_t;

	state_t   state_q;
	state_t   state_nxt;
	div_sel_t div_sel_q;

	always_comb begin
		cmd         = '0;
		cmd.div_sel = div_sel_q;
		state_nxt   = state_q;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = stat.plane_start ? S_DIV_GO : S_RANGE;
				end
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_nxt     = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (stat.div_done) begin
					cmd.div_store = 1'b1;
					state_nxt     = (div_sel_q == DIV_SEED_C) ? S_RANGE : S_DIV_GO;
				end
			end
			S_RANGE: begin
				cmd.range = 1'b1;
				state_nxt = stat.any ? S_RD : S_ADV;
			end
			S_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = S_WR;
			end
			S_WR: begin
				if (!stat.emit || stat.out_free) begin
					cmd.wr = 1'b1;
					if (!stat.pw_end) begin
						cmd.step_pw = 1'b1;
						state_nxt   = S_RD;
					end else if (!stat.ph_end) begin
						cmd.step_ph = 1'b1;
						state_nxt   = S_RD;
					end else begin
						state_nxt = S_ADV;
					end
				end
			end
			S_ADV: begin
				cmd.adv   = 1'b1;
				state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_sel_q <= DIV_OUT_H;
		end else begin
			state_q <= state_nxt;
			if (cmd.accept) begin
				div_sel_q <= DIV_OUT_H;
			end else if (cmd.div_store && div_sel_q != DIV_SEED_C) begin
				div_sel_q <= div_sel_t'(div_sel_q + 2'd1);
			end
		end
	end

endmodule

// ----- hw/rtl/mpa_dpath.sv -----
// ----------------------------------------------------------------------------
// mpa_dpath
// Registers, plane geometry, window range trackers, running window stores
// and the output register.
// ----------------------------------------------------------------------------
module mpa_dpath
	import mpa_pkg::*;
#(
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_KERNEL  = DEF_MAX_KERNEL,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	output dp_stat_t                      stat,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] pooled_value,
	output logic [IDX_W-1:0]              argmax_index,
	output logic [COORD_W-1:0]            out_row,
	output logic [COORD_W-1:0]            out_col,
	output logic                          last_of_run,
	output logic                          end_of_plane
);

	localparam int RAW   = $clog2(MAX_KERNEL);
	localparam int CAW   = $clog2(MAX_WIDTH);
	localparam int DEPTH = 2 ** (RAW + CAW);
	localparam int AW    = RAW + CAW;

	// ---------------- register file
	logic [DIM_W-1:0]  reg_h_q, reg_w_q;
	logic [KERN_W-1:0] reg_kr_q, reg_kc_q, reg_sr_q, reg_sc_q;
	logic [PAD_W-1:0]  reg_pr_q, reg_pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_h_q  <= RST_DIM;
			reg_w_q  <= RST_DIM;
			reg_kr_q <= RST_KERN;
			reg_kc_q <= RST_KERN;
			reg_sr_q <= RST_KERN;
			reg_sc_q <= RST_KERN;
			reg_pr_q <= RST_PAD;
			reg_pc_q <= RST_PAD;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IN_HEIGHT:   reg_h_q  <= cfg_data[DIM_W-1:0];
				REG_IN_WIDTH:    reg_w_q  <= cfg_data[DIM_W-1:0];
				REG_KERNEL_ROWS: reg_kr_q <= cfg_data[KERN_W-1:0];
				REG_KERNEL_COLS: reg_kc_q <= cfg_data[KERN_W-1:0];
				REG_STRIDE_ROWS: reg_sr_q <= cfg_data[KERN_W-1:0];
				REG_STRIDE_COLS: reg_sc_q <= cfg_data[KERN_W-1:0];
				REG_PAD_ROWS:    reg_pr_q <= cfg_data[PAD_W-1:0];
				REG_PAD_COLS:    reg_pc_q <= cfg_data[PAD_W-1:0];
				default:         ;
			endcase
		end
	end

	// ---------------- clamped geometry
	logic [DIM_W-1:0]        h_c, w_c;
	logic [KERN_W-1:0]       kr_c, kc_c, sr_c, sc_c;
	logic [PAD_W-1:0]        pr_c, pc_c;
	logic signed [KERN_W+1:0] off_r, off_c;

	always_comb begin
		h_c  = (reg_h_q == '0) ? DIM_W'(1) :
		       (32'(reg_h_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : reg_h_q;
		w_c  = (reg_w_q == '0) ? DIM_W'(1) :
		       (32'(reg_w_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : reg_w_q;
		kr_c = (reg_kr_q == '0) ? KERN_W'(1) :
		       (32'(reg_kr_q) > MAX_KERNEL) ? KERN_W'(MAX_KERNEL) : reg_kr_q;
		kc_c = (reg_kc_q == '0) ? KERN_W'(1) :
		       (32'(reg_kc_q) > MAX_KERNEL) ? KERN_W'(MAX_KERNEL) : reg_kc_q;
		sr_c = (reg_sr_q == '0) ? KERN_W'(1) : reg_sr_q;
		sc_c = (reg_sc_q == '0) ? KERN_W'(1) : reg_sc_q;
		pr_c = (KERN_W'(reg_pr_q) >= kr_c) ? PAD_W'(kr_c - KERN_W'(1)) : reg_pr_q;
		pc_c = (KERN_W'(reg_pc_q) >= kc_c) ? PAD_W'(kc_c - KERN_W'(1)) : reg_pc_q;
		// offset of the lowest covering window: pad + stride - kernel
		off_r = $signed((KERN_W+2)'(pr_c)) + $signed((KERN_W+2)'(sr_c))
		        - $signed((KERN_W+2)'(kr_c));
		off_c = $signed((KERN_W+2)'(pc_c)) + $signed((KERN_W+2)'(sc_c))
		        - $signed((KERN_W+2)'(kc_c));
	end

	logic [DIM_W-1:0]  act_h_q, act_w_q;
	logic [KERN_W-1:0] act_kr_q, act_kc_q, act_sr_q, act_sc_q;
	logic [PAD_W-1:0]  act_pr_q, act_pc_q;
	logic              latch_en;

	assign latch_en = cmd.accept && stat.plane_start;

	always_ff @(posedge clk) begin
		if (latch_en) begin
			act_h_q  <= h_c;
			act_w_q  <= w_c;
			act_kr_q <= kr_c;
			act_kc_q <= kc_c;
			act_sr_q <= sr_c;
			act_sc_q <= sc_c;
			act_pr_q <= pr_c;
			act_pc_q <= pc_c;
		end
	end

	// ---------------- setup divider
	logic [CNT_W-1:0]  span_h, span_w;
	logic [CNT_W-1:0]  div_num;
	logic [KERN_W-1:0] div_den;
	logic              div_done;
	logic [CNT_W-1:0]  div_quo;
	logic [KERN_W-1:0] div_rem;
	logic [CNT_W:0]    dim_d;
	logic              span_short;
	logic [CNT_W-1:0]  dim_lim;

	assign span_h = CNT_W'(act_h_q) + CNT_W'({act_pr_q, 1'b0});
	assign span_w = CNT_W'(act_w_q) + CNT_W'({act_pc_q, 1'b0});

	always_comb begin
		unique case (cmd.div_sel)
			DIV_OUT_H:  begin div_num = span_h - CNT_W'(act_kr_q); div_den = act_sr_q; end
			DIV_OUT_W:  begin div_num = span_w - CNT_W'(act_kc_q); div_den = act_sc_q; end
			DIV_SEED_R: begin div_num = CNT_W'(act_pr_q);          div_den = act_sr_q; end
			DIV_SEED_C: begin div_num = CNT_W'(act_pc_q);          div_den = act_sc_q; end
			default:    begin div_num = '0;                        div_den = act_sr_q; end
		endcase
	end

	mpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign dim_d      = (CNT_W+1)'(div_quo) + (CNT_W+1)'(1);
	assign span_short = (cmd.div_sel == DIV_OUT_H) ? (span_h < CNT_W'(act_kr_q))
	                                               : (span_w < CNT_W'(act_kc_q));
	always_comb begin
		if (span_short) begin
			dim_lim = '0;
		end else if (cmd.div_sel == DIV_OUT_H) begin
			dim_lim = (32'(dim_d) > MAX_HEIGHT) ? CNT_W'(MAX_HEIGHT) : CNT_W'(dim_d);
		end else begin
			dim_lim = (32'(dim_d) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(dim_d);
		end
	end

	// ---------------- position and window range trackers
	logic [DIM_W-1:0]  row_q, col_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  lim_h_q, lim_w_q;
	logic [CNT_W-1:0]  rhi_quo_q, rlo_quo_q, chi_quo_q, clo_quo_q, chi_quo_seed_q;
	logic [KERN_W-1:0] rhi_rem_q, rlo_rem_q, chi_rem_q, clo_rem_q;
	logic [KERN_W-1:0] rlo_neg_q, clo_neg_q;
	logic [KERN_W-1:0] chi_rem_seed_q, clo_rem_seed_q, clo_neg_seed_q;
	logic [DIM_W:0]    col_inc, row_inc;

	assign col_inc = (DIM_W+1)'(col_q) + (DIM_W+1)'(1);
	assign row_inc = (DIM_W+1)'(row_q) + (DIM_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.adv) begin
			if (col_inc >= (DIM_W+1)'(act_w_q)) begin
				col_q <= '0;
				row_q <= (row_inc >= (DIM_W+1)'(act_h_q)) ? '0 : DIM_W'(row_inc);
			end else begin
				col_q <= DIM_W'(col_inc);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch_en) begin
			idx_q <= '0;
			// lower covering window starts at zero until the offset climbs to zero
			rlo_quo_q <= '0;
			rlo_neg_q <= off_r[KERN_W+1] ? KERN_W'(-off_r) : '0;
			rlo_rem_q <= off_r[KERN_W+1] ? '0 : KERN_W'(off_r);
			clo_quo_q <= '0;
			clo_neg_q <= off_c[KERN_W+1] ? KERN_W'(-off_c) : '0;
			clo_rem_q <= off_c[KERN_W+1] ? '0 : KERN_W'(off_c);
			clo_neg_seed_q <= off_c[KERN_W+1] ? KERN_W'(-off_c) : '0;
			clo_rem_seed_q <= off_c[KERN_W+1] ? '0 : KERN_W'(off_c);
		end else if (cmd.div_store) begin
			unique case (cmd.div_sel)
				DIV_OUT_H:  lim_h_q <= dim_lim;
				DIV_OUT_W:  lim_w_q <= dim_lim;
				DIV_SEED_R: begin
					rhi_quo_q <= div_quo;
					rhi_rem_q <= div_rem;
				end
				DIV_SEED_C: begin
					chi_quo_q      <= div_quo;
					chi_rem_q      <= div_rem;
					chi_quo_seed_q <= div_quo;
					chi_rem_seed_q <= div_rem;
				end
				default: ;
			endcase
		end else if (cmd.adv) begin
			idx_q <= idx_q + IDX_W'(1);
			if (col_inc >= (DIM_W+1)'(act_w_q)) begin
				// new row: column trackers restart, row trackers step
				chi_quo_q <= chi_quo_seed_q;
				chi_rem_q <= chi_rem_seed_q;
				clo_quo_q <= '0;
				clo_neg_q <= clo_neg_seed_q;
				clo_rem_q <= clo_rem_seed_q;
				if (rhi_rem_q + KERN_W'(1) == act_sr_q) begin
					rhi_rem_q <= '0;
					rhi_quo_q <= rhi_quo_q + CNT_W'(1);
				end else begin
					rhi_rem_q <= rhi_rem_q + KERN_W'(1);
				end
				if (rlo_neg_q != '0) begin
					rlo_neg_q <= rlo_neg_q - KERN_W'(1);
				end else if (rlo_rem_q + KERN_W'(1) == act_sr_q) begin
					rlo_rem_q <= '0;
					rlo_quo_q <= rlo_quo_q + CNT_W'(1);
				end else begin
					rlo_rem_q <= rlo_rem_q + KERN_W'(1);
				end
			end else begin
				if (chi_rem_q + KERN_W'(1) == act_sc_q) begin
					chi_rem_q <= '0;
					chi_quo_q <= chi_quo_q + CNT_W'(1);
				end else begin
					chi_rem_q <= chi_rem_q + KERN_W'(1);
				end
				if (clo_neg_q != '0) begin
					clo_neg_q <= clo_neg_q - KERN_W'(1);
				end else if (clo_rem_q + KERN_W'(1) == act_sc_q) begin
					clo_rem_q <= '0;
					clo_quo_q <= clo_quo_q + CNT_W'(1);
				end else begin
					clo_rem_q <= clo_rem_q + KERN_W'(1);
				end
			end
		end
	end

	// ---------------- covering window ranges
	logic [CNT_W-1:0] rlo, clo, rhic, chic;
	logic             rany, cany;
	logic [CNT_W-1:0] ph_q, pw_q, rhi_c_q, chi_c_q, clo_c_q;

	always_comb begin
		rlo  = (rlo_neg_q != '0) ? '0 : rlo_quo_q;
		clo  = (clo_neg_q != '0) ? '0 : clo_quo_q;
		rany = (lim_h_q != '0) && (rlo <= rhi_quo_q) && (rlo < lim_h_q);
		cany = (lim_w_q != '0) && (clo <= chi_quo_q) && (clo < lim_w_q);
		rhic = (rhi_quo_q >= lim_h_q) ? lim_h_q - CNT_W'(1) : rhi_quo_q;
		chic = (chi_quo_q >= lim_w_q) ? lim_w_q - CNT_W'(1) : chi_quo_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.range) begin
			ph_q    <= rlo;
			pw_q    <= clo;
			rhi_c_q <= rhic;
			chi_c_q <= chic;
			clo_c_q <= clo;
		end else if (cmd.step_pw) begin
			pw_q <= pw_q + CNT_W'(1);
		end else if (cmd.step_ph) begin
			ph_q <= ph_q + CNT_W'(1);
			pw_q <= clo_c_q;
		end
	end

	// ---------------- window bounds of the current pair
	logic [CNT_W+KERN_W-1:0]   prod_r, prod_c;
	logic signed [ARITH_W-1:0] st_r, st_c, en_r, en_c, r1, c1, hs, ws;
	logic                      first_r, first_c, end_r, end_c, top_r, top_c;
	logic                      first_q, emit_q, last_q, eop_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	always_comb begin
		prod_r  = (CNT_W+KERN_W)'(ph_q) * (CNT_W+KERN_W)'(act_sr_q);
		prod_c  = (CNT_W+KERN_W)'(pw_q) * (CNT_W+KERN_W)'(act_sc_q);
		st_r    = $signed(ARITH_W'(prod_r)) - $signed(ARITH_W'(act_pr_q));
		st_c    = $signed(ARITH_W'(prod_c)) - $signed(ARITH_W'(act_pc_q));
		en_r    = st_r + $signed(ARITH_W'(act_kr_q));
		en_c    = st_c + $signed(ARITH_W'(act_kc_q));
		r1      = $signed(ARITH_W'(row_q)) + $signed(ARITH_W'(1));
		c1      = $signed(ARITH_W'(col_q)) + $signed(ARITH_W'(1));
		hs      = $signed(ARITH_W'(act_h_q));
		ws      = $signed(ARITH_W'(act_w_q));
		first_r = (st_r == $signed(ARITH_W'(row_q))) || (row_q == '0 && st_r <= 0);
		first_c = (st_c == $signed(ARITH_W'(col_q))) || (col_q == '0 && st_c <= 0);
		end_r   = (en_r <= hs) ? (en_r == r1) : (r1 == hs);
		end_c   = (en_c <= ws) ? (en_c == c1) : (c1 == ws);
		// on the last row or column every clipped window ends here, the top one last
		top_r   = end_r && ((r1 != hs) || (ph_q == rhi_c_q));
		top_c   = end_c && ((c1 != ws) || (pw_q == chi_c_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
		end
		if (cmd.rd) begin
			first_q <= first_r && first_c;
			emit_q  <= end_r && end_c;
			last_q  <= top_r && top_c;
			eop_q   <= (ph_q == lim_h_q - CNT_W'(1)) && (pw_q == lim_w_q - CNT_W'(1));
		end
	end

	// ---------------- running max and argmax stores
	logic [AW-1:0]                 slot;
	logic [31:0]                   ph_ext, pw_ext;
	logic [SAMPLE_BITS-1:0]        max_rd;
	logic [IDX_W-1:0]              idx_rd;
	logic                          take;
	logic                          st_we;
	logic signed [SAMPLE_BITS-1:0] new_val;
	logic [IDX_W-1:0]              new_idx;

	assign ph_ext  = 32'(ph_q);
	assign pw_ext  = 32'(pw_q);
	assign slot    = {ph_ext[RAW-1:0], pw_ext[CAW-1:0]};
	assign take    = first_q || (sample_q > $signed(max_rd));
	assign st_we   = cmd.wr && take;
	assign new_val = take ? sample_q : $signed(max_rd);
	assign new_idx = take ? idx_q : idx_rd;

	mpa_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_max_ram (
		.clk     (clk),
		.wr_en   (st_we),
		.wr_addr (slot),
		.wr_data (sample_q),
		.rd_en   (cmd.rd),
		.rd_addr (slot),
		.rd_data (max_rd)
	);

	mpa_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_idx_ram (
		.clk     (clk),
		.wr_en   (st_we),
		.wr_addr (slot),
		.wr_data (idx_q),
		.rd_en   (cmd.rd),
		.rd_addr (slot),
		.rd_data (idx_rd)
	);

	// ---------------- output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wr && emit_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && emit_q) begin
			pooled_value <= new_val;
			argmax_index <= new_idx;
			out_row      <= ph_q[COORD_W-1:0];
			out_col      <= pw_q[COORD_W-1:0];
			last_of_run  <= last_q;
			end_of_plane <= eop_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.plane_start = (row_q == '0) && (col_q == '0);
		stat.div_done    = div_done;
		stat.any         = rany && cany;
		stat.emit        = emit_q;
		stat.out_free    = !out_valid_q || out_ready;
		stat.pw_end      = (pw_q == chi_c_q);
		stat.ph_end      = (ph_q == rhi_c_q);
	end

endmodule

// ----- hw/rtl/max_pool_2d_argmax.sv -----
// per sample: accept, window range set-up, then a read and an update for each of the n windows
//   covering it (n is 1 for 2x2 stride 2), then advance; the output side can hold an update back
// the first sample of a plane adds 4 serial divisions before the window range set-up
// samples: one at a time; a new one is taken only once all windows of the last one are done
// reset: asynchronous, clears position, sequencer and output valid; registers
//   return to defaults; window stores are not cleared (every slot is written first)
// ----------------------------------------------------------------------------
// max_pool_2d_argmax
// Streaming 2-d max pooling with argmax over one raster-order plane.
// ----------------------------------------------------------------------------
module max_pool_2d_argmax
	import mpa_pkg::*;
#(
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_KERNEL  = DEF_MAX_KERNEL,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample requests
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	// result requests
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] pooled_value,
	output logic [IDX_W-1:0]              argmax_index,
	output logic [COORD_W-1:0]            out_row,
	output logic [COORD_W-1:0]            out_col,
	output logic                          last_of_run,
	output logic                          end_of_plane,
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// register writes never stall; they take effect at the next plane start
	assign cfg_ready = 1'b1;

	// sequencer: setup divisions, then a read and an update per covering window
	mpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// geometry, range trackers, running window stores and the output register,
	// which lets a finished result wait while the next window is worked on
	mpa_dpath #(
		.MAX_HEIGHT  (MAX_HEIGHT),
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_KERNEL  (MAX_KERNEL),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample       (sample),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.pooled_value (pooled_value),
		.argmax_index (argmax_index),
		.out_row      (out_row),
		.out_col      (out_col),
		.last_of_run  (last_of_run),
		.end_of_plane (end_of_plane)
	);

endmodule

// ----- hw/rtl/mpa_chk.sv -----
// ----------------------------------------------------------------------------
// mpa_chk
// Port-level checks of the pooling block, bound to the top level.
// ----------------------------------------------------------------------------
module mpa_chk
	import mpa_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] pooled_value,
	input logic [IDX_W-1:0]       argmax_index,
	input logic                   last_of_run,
	input logic                   end_of_plane
);

	// a held result request keeps its value, its index and its last-of-run flag
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pooled_value)
		&& $stable(argmax_index) && $stable(last_of_run))
		else $error("result changed while stalled");

	// the plane's final window is the last result of its sample
	a_eop_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_plane |-> last_of_run)
		else $error("end of plane without last of run");

	// while a run is still open no new sample is taken
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !in_ready)
		else $error("sample taken during an open run");

	// one sample at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("samples taken back to back");

endmodule

bind max_pool_2d_argmax mpa_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_mpa_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.pooled_value (pooled_value),
	.argmax_index (argmax_index),
	.last_of_run  (last_of_run),
	.end_of_plane (end_of_plane)
);
